[sv/ushc_pkg.sv]
// Shared types and constants for the ustar header checker.
package ushc_pkg;

  // header byte offsets
  localparam logic [8:0] HDR_LAST   = 9'd511;
  localparam logic [8:0] SIZE_FIRST = 9'd124;
  localparam logic [8:0] SIZE_END   = 9'd136;
  localparam logic [8:0] CK_FIRST   = 9'd148;
  localparam logic [8:0] CK_END     = 9'd156;
  localparam logic [8:0] TYPE_POS   = 9'd156;
  localparam logic [8:0] LINK_POS   = 9'd157;
  localparam logic [8:0] MAGIC_POS  = 9'd257;
  localparam logic [8:0] MAGIC_END  = 9'd262;
  localparam logic [8:0] MAGIC6_POS = 9'd262;
  localparam logic [8:0] VER_POS    = 9'd263;
  localparam logic [8:0] VER2_POS   = 9'd264;

  // characters
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_SYMLINK = 8'h32;
  localparam logic [7:0] CH_DIR     = 8'h35;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_END        = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC  = 3'd2;
  localparam logic [2:0] ST_BAD_CKSUM  = 3'd3;
  localparam logic [2:0] ST_BAD_LINK   = 3'd4;

  // entry type codes
  localparam logic [1:0] ET_REGULAR = 2'd0;
  localparam logic [1:0] ET_SYMLINK = 2'd1;
  localparam logic [1:0] ET_DIR     = 2'd2;
  localparam logic [1:0] ET_UNKNOWN = 2'd3;

  // size field parse phases
  localparam logic [1:0] SZ_LEAD   = 2'd0;
  localparam logic [1:0] SZ_DIGITS = 2'd1;
  localparam logic [1:0] SZ_DONE   = 2'd2;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  entry_type;
    logic [35:0] file_size;
    logic [27:0] payload_blocks;
  } result_t;

endpackage

[sv/ushc_hdr.sv]
// Per-byte header state: running sum, field parsers, end-of-header verdict.
module ushc_hdr import ushc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [7:0] b,
  input  logic       strict_mode,
  output logic       res_valid,
  output result_t    res
);

  logic [8:0]  pos, pos_next;
  logic [16:0] byte_sum, byte_sum_next;
  logic [23:0] ck, ck_next;
  logic        ck_done, ck_done_next;
  logic [35:0] size_value, size_value_next;
  logic [1:0]  size_phase, size_phase_next;
  logic        magic_good, magic_good_next;
  logic [7:0]  type_byte, type_byte_next;
  logic        link_nonempty, link_nonempty_next;
  logic        header_empty, header_empty_next;
  logic        previous_empty, previous_empty_next;
  logic [36:0] left, left_next;
  logic        halted, halted_next;

  logic [7:0]  sum_add;
  logic [8:0]  magic_off;
  logic [36:0] size_round;
  logic        b_octal, b_blank;

  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    unique case (idx)
      3'd0:    c = 8'h75; // u
      3'd1:    c = 8'h73; // s
      3'd2:    c = 8'h74; // t
      3'd3:    c = 8'h61; // a
      3'd4:    c = 8'h72; // r
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  assign b_octal    = (b[7:3] == CH_ZERO[7:3]);
  assign b_blank    = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  assign magic_off  = pos - MAGIC_POS;
  assign size_round = {1'b0, size_value} + 37'd511;

  always_comb begin
    pos_next            = pos;
    byte_sum_next       = byte_sum;
    ck_next             = ck;
    ck_done_next        = ck_done;
    size_value_next     = size_value;
    size_phase_next     = size_phase;
    magic_good_next     = magic_good;
    type_byte_next      = type_byte;
    link_nonempty_next  = link_nonempty;
    header_empty_next   = header_empty;
    previous_empty_next = previous_empty;
    left_next           = left;
    halted_next         = halted;
    sum_add             = b;
    res_valid           = 1'b0;
    res                 = '0;

    if (en && !halted) begin
      if (left != '0) begin
        left_next = left - 37'd1;
      end else begin
        if (pos == '0) begin
          header_empty_next = (b == 8'h00);
        end
        // checksum field counts as spaces
        if (pos >= CK_FIRST && pos < CK_END) begin
          sum_add = CH_SPACE;
          if (!ck_done) begin
            if (b_octal) begin
              ck_next = {ck[20:0], b[2:0]};
            end else begin
              ck_done_next = 1'b1;
            end
          end
        end
        byte_sum_next = byte_sum + {9'd0, sum_add};

        if (pos >= SIZE_FIRST && pos < SIZE_END && size_phase != SZ_DONE) begin
          if (size_phase == SZ_LEAD && b_blank) begin
            size_phase_next = SZ_LEAD;
          end else if (b_octal) begin
            size_value_next = {size_value[32:0], b[2:0]};
            size_phase_next = SZ_DIGITS;
          end else begin
            size_phase_next = SZ_DONE;
          end
        end

        if (pos == TYPE_POS) type_byte_next = b;
        if (pos == LINK_POS) link_nonempty_next = (b != 8'h00);
        if (pos >= MAGIC_POS && pos < MAGIC_END && b != magic_char(magic_off[2:0]))
          magic_good_next = 1'b0;
        if (pos == MAGIC6_POS && strict_mode && b == CH_ZERO)
          magic_good_next = 1'b0;
        if ((pos == VER_POS || pos == VER2_POS) && strict_mode && b != CH_ZERO)
          magic_good_next = 1'b0;

        if (pos != HDR_LAST) begin
          pos_next = pos + 9'd1;
        end else begin
          // end of header: verdict, then clear per-header state
          if (header_empty) begin
            if (previous_empty) begin
              res_valid   = 1'b1;
              res.status  = ST_END;
              halted_next = 1'b1;
            end else begin
              previous_empty_next = 1'b1;
            end
          end else begin
            previous_empty_next = 1'b0;
            res_valid           = 1'b1;
            priority if (!magic_good) begin
              res.status = ST_BAD_MAGIC;
            end else if ({7'd0, byte_sum_next} != ck) begin
              res.status = ST_BAD_CKSUM;
            end else if (type_byte == CH_SYMLINK && !link_nonempty) begin
              res.status = ST_BAD_LINK;
            end else begin
              res.status = ST_OK;
            end
            if (res.status != ST_OK) begin
              halted_next = 1'b1;
            end else begin
              res.file_size = size_value;
              priority if (type_byte == 8'h00 || type_byte == CH_ZERO) begin
                res.entry_type     = ET_REGULAR;
                res.payload_blocks = size_round[36:9];
                left_next          = {size_round[36:9], 9'd0};
              end else if (type_byte == CH_SYMLINK) begin
                res.entry_type = ET_SYMLINK;
              end else if (type_byte == CH_DIR) begin
                res.entry_type = ET_DIR;
              end else begin
                res.entry_type = ET_UNKNOWN;
              end
            end
          end
          pos_next           = '0;
          byte_sum_next      = '0;
          ck_next            = '0;
          ck_done_next       = 1'b0;
          size_value_next    = '0;
          size_phase_next    = SZ_LEAD;
          magic_good_next    = 1'b1;
          type_byte_next     = '0;
          link_nonempty_next = 1'b0;
          header_empty_next  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos            <= '0;
      byte_sum       <= '0;
      ck             <= '0;
      ck_done        <= 1'b0;
      size_value     <= '0;
      size_phase     <= SZ_LEAD;
      magic_good     <= 1'b1;
      type_byte      <= '0;
      link_nonempty  <= 1'b0;
      header_empty   <= 1'b0;
      previous_empty <= 1'b0;
      left           <= '0;
      halted         <= 1'b0;
    end else begin
      pos            <= pos_next;
      byte_sum       <= byte_sum_next;
      ck             <= ck_next;
      ck_done        <= ck_done_next;
      size_value     <= size_value_next;
      size_phase     <= size_phase_next;
      magic_good     <= magic_good_next;
      type_byte      <= type_byte_next;
      link_nonempty  <= link_nonempty_next;
      header_empty   <= header_empty_next;
      previous_empty <= previous_empty_next;
      left           <= left_next;
      halted         <= halted_next;
    end
  end

`ifndef ASSERT_OFF
  // once halted, only reset leaves the halted state
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted) else $error("halted state dropped without reset");

  // a failing verdict halts the block
  a_fail_halts: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status != ST_OK) |=> halted)
    else $error("error status did not halt");

  // no verdict while skipping payload
  a_skip_quiet: assert property (@(posedge clk) disable iff (rst)
    (left != '0) |-> !res_valid) else $error("result during payload skip");

  // payload skip only starts at a header boundary
  a_skip_aligned: assert property (@(posedge clk) disable iff (rst)
    (left != '0) |-> (pos == '0)) else $error("payload skip mid-header");
`endif

endmodule

[sv/ushc_out_reg.sv]
// Result register with valid/stall handshake toward the receiver.
module ushc_out_reg import ushc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     res,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [2:0]  status,
  output logic [1:0]  entry_type,
  output logic [35:0] file_size,
  output logic [27:0] payload_blocks
);

  result_t data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

  assign status         = data.status;
  assign entry_type     = data.entry_type;
  assign file_size      = data.file_size;
  assign payload_blocks = data.payload_blocks;

endmodule

[sv/ustar_header_checker_core.sv]
// Top level of the ustar header checker: input register, header logic, result register.
//
// Usage:
//   Input channel (in_valid / in_stall / archive_byte) carries the raw archive
//   stream, one byte per transaction, headers and payload alike. Each 512-byte
//   header yields one result transaction on the output channel (out_valid /
//   out_stall / status, entry_type, file_size, payload_blocks), except a lone
//   empty header which is skipped. Payload of regular files is consumed silently.
// Throughput: one byte per cycle unless a full result register is stalled;
//   the header logic is a single register-to-register step per byte.
// Result path: the last byte of a header waits in the input register, and its
//   verdict is formed combinationally and captured in the result register.
// Stall: while the receiver stalls and the result register is full, the input
//   register keeps one byte and in_stall rises only if it holds one, so the
//   sender is held back without losing data.
// Reset (rst, synchronous): clears header state, the payload skip counter, the
//   halt flag and strict_mode. Any status other than ok halts the block; all
//   later bytes are accepted and dropped until reset.
// Configuration: cfg_we writes cfg_data into strict_mode; write only while idle.
module ustar_header_checker_core import ushc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  archive_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [1:0]  entry_type,
  output logic [35:0] file_size,
  output logic [27:0] payload_blocks
);

  logic       strict_mode;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       advance;
  logic       in_accept;
  logic       res_valid;
  result_t    res;

  // the byte in the input register moves on when the result slot is free or not stalled
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      strict_mode <= 1'b0;
    end else if (cfg_we) begin
      strict_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte <= archive_byte;
    end
  end

  ushc_hdr u_hdr (
    .clk         (clk),
    .rst         (rst),
    .en          (s1_valid && advance),
    .b           (s1_byte),
    .strict_mode (strict_mode),
    .res_valid   (res_valid),
    .res         (res)
  );

  ushc_out_reg u_out (
    .clk            (clk),
    .rst            (rst),
    .load           (res_valid),
    .res            (res),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .status         (status),
    .entry_type     (entry_type),
    .file_size      (file_size),
    .payload_blocks (payload_blocks)
  );

endmodule
